// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define CSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("allocator check failed");

// Clocked check that also runs during reset.
`define CSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("allocator check failed");

`endif

// ===== hw/rtl/csa_pkg.sv =====
// Shared constants, codes and types of the chunked stack slot allocator.
package csa_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int MAX_GROUP  = 64;

  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int TOP_W     = SLOT_W + 1;
  localparam int CFG_W     = 13;
  localparam int GROUP_W   = 7;
  localparam int CODE_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Occupancy store organized as rows of bits.
  localparam int ROW_BITS  = 32;
  localparam int ROW_W     = $clog2(ROW_BITS);
  localparam int ROW_COUNT = SLOT_COUNT / ROW_BITS;
  localparam int ROW_IDX_W = SLOT_W - ROW_W;

  // Remainder unit width.
  localparam int DIV_W    = (CFG_W > TOP_W) ? CFG_W : TOP_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0] CHUNK_RESET    = CFG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 1'b0,
    CFG_CHUNK    = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [CODE_W-1:0] {
    RES_OK   = 2'd0,
    RES_FULL = 2'd1,
    RES_WARN = 2'd2
  } res_code_e;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_IDX_W-1:0] rd_addr;
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] wr_addr;
    logic [ROW_BITS-1:0]  wdata;
  } csa_mem_req_t;

endpackage

// ===== hw/rtl/chunked_stack_slot_allocator_core.sv =====
// Allocate: remainder unit, capacity check, then a read and a write per touched row; a group
// of 64 touches up to 3 rows. Zero or oversized groups and capacity refusals go straight to
// the result. Free: the freed slot's row is read and written, then further occupancy rows
// are read while the top walks down. One word at a time; the next is taken in the cycle after
// a result is posted, even while it waits. Reset: every slot free (row valid bits cleared at
// once), top 0, capacity 4096, chunk 1024. Top level of the chunked stack slot allocator.
`include "assert_macros.svh"

module chunked_stack_slot_allocator_core
  import csa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [GROUP_W-1:0]   group_count_i,
  input  logic [SLOT_W-1:0]    slot_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SLOT_W-1:0]    first_slot_o,
  output logic [CODE_W-1:0]    result_code_o,
  output logic [TOP_W-1:0]     top_count_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_RD,
    S_MOD,
    S_EMIT
  } state_e;

  state_e               state_q;
  logic [CFG_W-1:0]     capacity_q;
  logic [CFG_W-1:0]     chunk_q;
  logic [TOP_W-1:0]     stack_top_q;
  logic                 op_q;
  logic [GROUP_W-1:0]   group_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [DIV_W:0]       base_q;
  logic [SLOT_W-1:0]    first_q;
  logic [SLOT_W-1:0]    end_q;
  logic [ROW_IDX_W-1:0] row_q;
  logic                 warn_q;
  logic                 walk_q;
  logic [SLOT_W-1:0]    res_first_q;
  logic [CODE_W-1:0]    res_code_q;
  logic                 out_valid_q;
  logic [SLOT_W-1:0]    out_first_q;
  logic [CODE_W-1:0]    out_code_q;
  logic [TOP_W-1:0]     out_top_q;

  logic [CFG_W-1:0]     chunk_eff;
  logic [TOP_W-1:0]     cap_eff;
  logic                 in_acc;
  logic                 grp_zero;
  logic                 grp_big;
  logic                 rem_start;
  logic                 rem_done;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W:0]       base_jump;
  logic [DIV_W+1:0]     grp_end;
  csa_mem_req_t         mem_req;
  logic [ROW_BITS-1:0]  rdata;
  logic [ROW_W-1:0]     lo;
  logic [ROW_W-1:0]     hi;
  logic                 first_row;
  logic                 last_row;
  logic [ROW_BITS-1:0]  grp_mask;
  logic [ROW_BITS-1:0]  clr_row;
  logic [ROW_BITS-1:0]  srch;
  logic                 found;
  logic [ROW_W-1:0]     pos;
  logic                 top_hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      chunk_q    <= CHUNK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITY: capacity_q <= cfg_wdata_i;
        CFG_CHUNK:    chunk_q    <= cfg_wdata_i;
        default:      ;
      endcase
    end
  end

  assign chunk_eff = (chunk_q == '0) ? CFG_W'(1) : chunk_q;
  assign cap_eff   = (32'(capacity_q) > 32'(SLOT_COUNT)) ? TOP_W'(SLOT_COUNT)
                                                          : TOP_W'(capacity_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign grp_zero   = (group_count_i == '0);
  assign grp_big    = (32'(group_count_i) > 32'(MAX_GROUP)) ||
                      (CFG_W'(group_count_i) > chunk_eff);
  assign rem_start  = in_acc && (operation_i == OP_ALLOC) && !grp_zero && !grp_big;

  csa_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (DIV_W'(stack_top_q)),
    .divisor_i  (DIV_W'(chunk_eff)),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Jump to the next chunk start when the group would cross a boundary.
  always_comb begin
    if ((DIV_W + 1)'(rem) + (DIV_W + 1)'(group_q) > (DIV_W + 1)'(chunk_eff)) begin
      base_jump = (DIV_W + 1)'(stack_top_q) - (DIV_W + 1)'(rem) + (DIV_W + 1)'(chunk_eff);
    end else begin
      base_jump = (DIV_W + 1)'(stack_top_q);
    end
  end

  assign grp_end = (DIV_W + 2)'(base_q) + (DIV_W + 2)'(group_q);

  csa_occ_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign first_row = (row_q == first_q[SLOT_W-1:ROW_W]);
  assign last_row  = (row_q == end_q[SLOT_W-1:ROW_W]);
  assign lo        = first_row ? first_q[ROW_W-1:0] : '0;
  assign hi        = last_row ? end_q[ROW_W-1:0] : '1;
  assign top_hit   = (TOP_W'(slot_q) + TOP_W'(1) == stack_top_q);

  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      grp_mask[j] = (ROW_W'(j) >= lo) && (ROW_W'(j) <= hi);
      clr_row[j]  = rdata[j] && (ROW_W'(j) != slot_q[ROW_W-1:0]);
      // first step of a walk only looks below the freed slot
      if (walk_q) begin
        srch[j] = rdata[j];
      end else begin
        srch[j] = clr_row[j] && (ROW_W'(j) <= slot_q[ROW_W-1:0]);
      end
    end
  end

  // Highest occupied slot in the row
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      if (srch[j]) begin
        found = 1'b1;
        pos   = ROW_W'(j);
      end
    end
  end

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = (state_q == S_RD);
    mem_req.rd_addr = row_q;
    mem_req.wr_addr = row_q;
    if (state_q == S_MOD) begin
      if (op_q == OP_ALLOC) begin
        mem_req.wr_en = 1'b1;
        mem_req.wdata = rdata | grp_mask;
      end else if (!walk_q) begin
        mem_req.wr_en = 1'b1;
        mem_req.wdata = clr_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stack_top_q <= '0;
      op_q        <= OP_ALLOC;
      group_q     <= '0;
      slot_q      <= '0;
      base_q      <= '0;
      first_q     <= '0;
      end_q       <= '0;
      row_q       <= '0;
      warn_q      <= 1'b0;
      walk_q      <= 1'b0;
      res_first_q <= '0;
      res_code_q  <= RES_OK;
      out_valid_q <= 1'b0;
      out_first_q <= '0;
      out_code_q  <= RES_OK;
      out_top_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q        <= operation_i;
            group_q     <= group_count_i;
            slot_q      <= slot_index_i;
            warn_q      <= 1'b0;
            walk_q      <= 1'b0;
            res_first_q <= (operation_i == OP_ALLOC && grp_zero) ? stack_top_q[SLOT_W-1:0]
                                                                 : '0;
            res_code_q  <= (operation_i == OP_ALLOC && !grp_zero && grp_big) ? RES_FULL
                                                                             : RES_OK;
            if (operation_i == OP_FREE) begin
              row_q   <= slot_index_i[SLOT_W-1:ROW_W];
              state_q <= S_RD;
            end else if (grp_zero || grp_big) begin
              state_q <= S_EMIT;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem_done) begin
            base_q  <= base_jump;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (grp_end > (DIV_W + 2)'(cap_eff)) begin
            res_code_q <= RES_FULL;
            state_q    <= S_EMIT;
          end else begin
            first_q <= base_q[SLOT_W-1:0];
            end_q   <= SLOT_W'(grp_end - (DIV_W + 2)'(1));
            row_q   <= base_q[SLOT_W-1:ROW_W];
            state_q <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_MOD;
        end
        S_MOD: begin
          if (op_q == OP_ALLOC) begin
            if (last_row) begin
              stack_top_q <= TOP_W'(end_q) + TOP_W'(1);
              res_first_q <= first_q;
              res_code_q  <= (warn_q || |(rdata & grp_mask)) ? RES_WARN : RES_OK;
              state_q     <= S_EMIT;
            end else begin
              warn_q  <= warn_q || |(rdata & grp_mask);
              row_q   <= row_q + ROW_IDX_W'(1);
              state_q <= S_RD;
            end
          end else if (!walk_q && !top_hit) begin
            state_q <= S_EMIT;
          end else if (found) begin
            stack_top_q <= TOP_W'({row_q, pos}) + TOP_W'(1);
            state_q     <= S_EMIT;
          end else if (row_q == '0) begin
            stack_top_q <= '0;
            state_q     <= S_EMIT;
          end else begin
            walk_q  <= 1'b1;
            row_q   <= row_q - ROW_IDX_W'(1);
            state_q <= S_RD;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_first_q <= res_first_q;
            out_code_q  <= res_code_q;
            out_top_q   <= stack_top_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign first_slot_o  = out_first_q;
  assign result_code_o = out_code_q;
  assign top_count_o   = out_top_q;

  `CSA_ASSERT(a_top_in_range, stack_top_q <= TOP_W'(SLOT_COUNT))
  `CSA_ASSERT(a_full_first_zero, out_valid_o && result_code_o == RES_FULL |-> first_slot_o == '0)
  `CSA_ASSERT(a_rem_done_in_div, rem_done |-> state_q == S_DIV)
  `CSA_ASSERT(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q != S_IDLE)

endmodule

// ===== hw/rtl/csa_occ_mem.sv =====
// Occupancy row memory with per-row valid bits; unwritten rows read as free.
module csa_occ_mem
  import csa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  csa_mem_req_t        req_i,
  output logic [ROW_BITS-1:0] rdata_o
);

  logic [ROW_BITS-1:0]  mem_q [ROW_COUNT];
  logic [ROW_COUNT-1:0] row_vld_q;
  logic [ROW_BITS-1:0]  rdata_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

// ===== hw/rtl/csa_rem_unit.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module csa_rem_unit
  import csa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  logic [DIV_W:0]     rem_q;
  logic [DIV_W-1:0]   dvd_q;
  logic [DIV_W-1:0]   dvs_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DIV_W:0]     trial;

  assign trial = {rem_q[DIV_W-1:0], dvd_q[DIV_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        cnt_q  <= DIV_CNT_W'(DIV_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_q <= trial - {1'b0, dvs_q};
        end else begin
          rem_q <= trial;
        end
        dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[DIV_W-1:0];

endmodule
